[hw/rtl/set_assoc_cache_lru_sim_top_defines.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the set-associative cache tag store
// Concurrent checks that compile away when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef SET_ASSOC_CACHE_LRU_SIM_TOP_DEFINES_SVH
`define SET_ASSOC_CACHE_LRU_SIM_TOP_DEFINES_SVH

`ifndef SYNTHESIS
// same-cycle implication
`define SAC_ASSERT_NOW(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);
// next-cycle implication
`define SAC_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);
`else
`define SAC_ASSERT_NOW(lbl, clk, rstn, ante, cons, msg)
`define SAC_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg)
`endif

`endif

[hw/rtl/sac_pkg.sv]
// ----------------------------------------------------------------------------
// sac_pkg
// Shared constants, codes and types of the cache tag store.
// ----------------------------------------------------------------------------
package sac_pkg;

    // default geometry
    localparam int DEF_MAX_SET_BITS = 6;
    localparam int DEF_WAYS         = 8;
    localparam int DEF_ADDR_WIDTH   = 32;
    localparam int DEF_STAMP_WIDTH  = 32;

    // depth of the queue between front and back
    localparam int QUEUE_DEPTH = 2;

    // counter widths and saturation value
    localparam int          TOTAL_WIDTH = 32;
    localparam logic [31:0] TOTAL_MAX   = 32'hFFFF_FFFF;

    // access kinds
    localparam logic [1:0] KIND_LOAD   = 2'd0;
    localparam logic [1:0] KIND_STORE  = 2'd1;
    localparam logic [1:0] KIND_MODIFY = 2'd2;
    localparam logic [1:0] KIND_NONE   = 2'd3;

    // register indexes on the APB port
    localparam logic [1:0] REG_SET_BITS    = 2'd0;
    localparam logic [1:0] REG_OFFSET_BITS = 2'd1;
    localparam logic [1:0] REG_WAYS        = 2'd2;

    // register reset values
    localparam logic [2:0] RST_SET_BITS    = 3'd4;
    localparam logic [4:0] RST_OFFSET_BITS = 5'd4;
    localparam logic [3:0] RST_WAYS        = 4'd1;

    // configuration as seen by front and back
    typedef struct packed {
        logic [2:0] set_bits;
        logic [4:0] offset_bits;
        logic [3:0] ways_in_use;
    } t_cfg;

endpackage

[hw/rtl/sac_if.sv]
// ----------------------------------------------------------------------------
// Request and response channels
// Valid/ready channels carrying one trace access and its lookup result.
// ----------------------------------------------------------------------------

// access request channel
interface sac_req_if #(
    parameter int ADDR_WIDTH = 32
);
    logic                  valid;
    logic                  ready;
    logic [1:0]            kind;
    logic [ADDR_WIDTH-1:0] address;

    modport source (output valid, output kind, output address, input ready);
    modport sink   (input valid, input kind, input address, output ready);
endinterface

// lookup result channel
interface sac_rsp_if;
    logic        valid;
    logic        ready;
    logic [1:0]  hits_now;
    logic        missed;
    logic        evicted;
    logic [31:0] total_hits;
    logic [31:0] total_misses;
    logic [31:0] total_evictions;

    modport source (
        output valid, output hits_now, output missed, output evicted,
        output total_hits, output total_misses, output total_evictions,
        input ready
    );
    modport sink (
        input valid, input hits_now, input missed, input evicted,
        input total_hits, input total_misses, input total_evictions,
        output ready
    );
endinterface

[hw/rtl/sac_queue.sv]
// ----------------------------------------------------------------------------
// sac_queue
// Short FIFO of decoded requests between the front and the back.
// ----------------------------------------------------------------------------
module sac_queue import sac_pkg::*; #(
    parameter int WIDTH = 40
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data,
    output logic             o_empty
);
    localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    logic [WIDTH-1:0] r_mem [QUEUE_DEPTH];
    logic [PW-1:0]    r_wr_ptr, n_wr_ptr;
    logic [PW-1:0]    r_rd_ptr, n_rd_ptr;
    logic [CW-1:0]    r_count,  n_count;

    assign o_full  = (r_count == CW'(QUEUE_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_data  = r_mem[r_rd_ptr];

    // pointer and count update
    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == PW'(QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (i_pop) begin
            n_rd_ptr = (r_rd_ptr == PW'(QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (!i_push && i_pop) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

endmodule

[hw/rtl/sac_front.sv]
// ----------------------------------------------------------------------------
// sac_front
// Accepts trace requests, splits the address into set and tag and queues them.
// ----------------------------------------------------------------------------
module sac_front import sac_pkg::*; #(
    parameter int MAX_SET_BITS = DEF_MAX_SET_BITS,
    parameter int ADDR_WIDTH   = DEF_ADDR_WIDTH,
    parameter int SIW          = (MAX_SET_BITS > 0) ? MAX_SET_BITS : 1,
    parameter int EW           = 2 + SIW + ADDR_WIDTH
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  t_cfg          i_cfg,
    input  logic          i_clearing,
    sac_req_if.sink       i_req,
    input  logic          i_pop,
    output logic [EW-1:0] o_entry,
    output logic          o_empty
);
    logic            w_full;
    logic            w_push;
    logic [3:0]      w_sb;
    logic [5:0]      w_split;
    logic [SIW-1:0]  w_set_mask;
    logic [SIW-1:0]  w_set;
    logic [ADDR_WIDTH-1:0] w_tag;
    logic [1:0]      w_kind;

    // hold off while the line store is being cleared
    assign i_req.ready = !w_full && !i_clearing;
    assign w_push      = i_req.valid && i_req.ready;

    // set bits beyond the store's size are capped
    assign w_sb = (32'(i_cfg.set_bits) > MAX_SET_BITS) ? 4'(MAX_SET_BITS)
                                                       : {1'b0, i_cfg.set_bits};
    assign w_split = 6'(w_sb) + 6'(i_cfg.offset_bits);

    // mask of the set-select bits in use
    always_comb begin
        for (int i = 0; i < SIW; i++) begin
            w_set_mask[i] = (i < 32'(w_sb));
        end
    end

    // address split; a shift past the top yields zero
    assign w_set  = SIW'(i_req.address >> i_cfg.offset_bits) & w_set_mask;
    assign w_tag  = i_req.address >> w_split;

    // classify: the kind code passes as the operation, unknown kind does nothing
    always_comb begin
        case (i_req.kind)
            KIND_LOAD, KIND_STORE, KIND_MODIFY: w_kind = i_req.kind;
            default:                            w_kind = KIND_NONE;
        endcase
    end

    sac_queue #(
        .WIDTH (EW)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  ({w_kind, w_set, w_tag}),
        .o_full  (w_full),
        .i_pop   (i_pop),
        .o_data  (o_entry),
        .o_empty (o_empty)
    );

endmodule

[hw/rtl/sac_back.sv]
// ----------------------------------------------------------------------------
// sac_back
// Reads one set, resolves hit, fill or LRU eviction, writes the set back and
// presents the result with the running totals.
// ----------------------------------------------------------------------------
`include "set_assoc_cache_lru_sim_top_defines.svh"

module sac_back import sac_pkg::*; #(
    parameter int MAX_SET_BITS = DEF_MAX_SET_BITS,
    parameter int WAYS         = DEF_WAYS,
    parameter int ADDR_WIDTH   = DEF_ADDR_WIDTH,
    parameter int STAMP_WIDTH  = DEF_STAMP_WIDTH,
    parameter int SIW          = (MAX_SET_BITS > 0) ? MAX_SET_BITS : 1,
    parameter int EW           = 2 + SIW + ADDR_WIDTH
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  t_cfg          i_cfg,
    output logic          o_clearing,
    input  logic [EW-1:0] i_entry,
    input  logic          i_empty,
    output logic          o_pop,
    sac_rsp_if.source     o_rsp
);
    localparam int SETS = 1 << MAX_SET_BITS;
    localparam int WIW  = (WAYS > 1) ? $clog2(WAYS) : 1;
    localparam int WCW  = $clog2(WAYS + 1);
    localparam int LV   = (WAYS > 1) ? $clog2(WAYS) : 0;
    localparam int WP2  = 1 << LV;

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_LOOK = 1'b1;

    // line store, one row per set
    logic [WAYS-1:0]                        r_mem_valid [SETS];
    logic [WAYS-1:0][ADDR_WIDTH-1:0]        r_mem_tag   [SETS];
    logic [WAYS-1:0][STAMP_WIDTH-1:0]       r_mem_stamp [SETS];

    logic [WAYS-1:0]                        r_rd_valid;
    logic [WAYS-1:0][ADDR_WIDTH-1:0]        r_rd_tag;
    logic [WAYS-1:0][STAMP_WIDTH-1:0]       r_rd_stamp;

    logic                  r_state, n_state;
    logic                  r_clr_busy;
    logic [SIW-1:0]        r_clr_idx;
    logic [1:0]            r_ent_op;
    logic [SIW-1:0]        r_ent_set;
    logic [ADDR_WIDTH-1:0] r_ent_tag;
    logic [STAMP_WIDTH-1:0] r_stamp;
    logic [31:0]           r_hit_total, r_miss_total, r_evict_total;
    logic                  r_out_valid;
    logic [1:0]            r_out_hits;
    logic                  r_out_missed, r_out_evicted;

    logic                  w_slot_free;
    logic                  w_done;
    logic                  w_active;
    logic [WCW-1:0]        w_ways;
    logic [WAYS-1:0]       w_in_use, w_hit_vec, w_inv_vec;
    logic                  w_hit, w_empty_way;
    logic [WIW-1:0]        w_hit_way, w_inv_way, w_min_way, w_pick;
    logic [1:0]            w_hits;
    logic                  w_missed, w_evicted;
    logic [WAYS-1:0]                  w_valid_row;
    logic [WAYS-1:0][ADDR_WIDTH-1:0]  w_tag_row;
    logic [WAYS-1:0][STAMP_WIDTH-1:0] w_stamp_row;

    // LRU reduction tree
    logic [WIW-1:0]         t_idx [LV+1][WP2];
    logic [STAMP_WIDTH-1:0] t_stp [LV+1][WP2];
    logic                   t_use [LV+1][WP2];

    assign o_clearing  = r_clr_busy;
    assign w_slot_free = !r_out_valid || o_rsp.ready;
    assign o_pop       = (r_state == ST_IDLE) && !i_empty && !r_clr_busy;
    assign w_done      = (r_state == ST_LOOK) && w_slot_free;
    assign w_active    = (r_ent_op != KIND_NONE);

    // sequencer: read a set, then resolve and write it back
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: if (o_pop)  n_state = ST_LOOK;
            ST_LOOK: if (w_done) n_state = ST_IDLE;
            default:             n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // latch the popped request
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_ent_op  <= i_entry[EW-1 -: 2];
            r_ent_set <= i_entry[ADDR_WIDTH +: SIW];
            r_ent_tag <= i_entry[ADDR_WIDTH-1:0];
        end
    end

    // ways in use, clamped to 1..WAYS
    always_comb begin
        if (i_cfg.ways_in_use == '0) begin
            w_ways = WCW'(1);
        end else if (32'(i_cfg.ways_in_use) > WAYS) begin
            w_ways = WCW'(WAYS);
        end else begin
            w_ways = WCW'(i_cfg.ways_in_use);
        end
        for (int w = 0; w < WAYS; w++) begin
            w_in_use[w]  = (w < 32'(w_ways));
            w_hit_vec[w] = w_in_use[w] && r_rd_valid[w] && (r_rd_tag[w] == r_ent_tag);
            w_inv_vec[w] = w_in_use[w] && !r_rd_valid[w];
        end
    end

    // lowest matching way and lowest free way
    always_comb begin
        w_hit_way = '0;
        w_inv_way = '0;
        for (int w = WAYS - 1; w >= 0; w--) begin
            if (w_hit_vec[w]) w_hit_way = WIW'(w);
            if (w_inv_vec[w]) w_inv_way = WIW'(w);
        end
    end

    assign w_hit       = |w_hit_vec;
    assign w_empty_way = |w_inv_vec;

    // oldest stamp, ties to the lower way
    always_comb begin
        for (int l = 0; l <= LV; l++) begin
            for (int n = 0; n < WP2; n++) begin
                t_idx[l][n] = '0;
                t_stp[l][n] = '0;
                t_use[l][n] = 1'b0;
            end
        end
        for (int n = 0; n < WAYS; n++) begin
            t_idx[0][n] = WIW'(n);
            t_stp[0][n] = r_rd_stamp[n];
            t_use[0][n] = w_in_use[n];
        end
        for (int l = 1; l <= LV; l++) begin
            for (int n = 0; n < (WP2 >> l); n++) begin
                if (t_use[l-1][2*n+1] &&
                    (!t_use[l-1][2*n] || (t_stp[l-1][2*n+1] < t_stp[l-1][2*n]))) begin
                    t_idx[l][n] = t_idx[l-1][2*n+1];
                    t_stp[l][n] = t_stp[l-1][2*n+1];
                end else begin
                    t_idx[l][n] = t_idx[l-1][2*n];
                    t_stp[l][n] = t_stp[l-1][2*n];
                end
                t_use[l][n] = t_use[l-1][2*n] || t_use[l-1][2*n+1];
            end
        end
        w_min_way = t_idx[LV][0];
    end

    // outcome and updated row
    always_comb begin
        w_pick      = w_hit ? w_hit_way : (w_empty_way ? w_inv_way : w_min_way);
        w_missed    = w_active && !w_hit;
        w_evicted   = w_active && !w_hit && !w_empty_way;
        w_hits      = {1'b0, w_active && w_hit} + {1'b0, r_ent_op == KIND_MODIFY};
        w_valid_row = r_rd_valid;
        w_tag_row   = r_rd_tag;
        w_stamp_row = r_rd_stamp;
        w_stamp_row[w_pick] = r_stamp;
        if (!w_hit) begin
            w_valid_row[w_pick] = 1'b1;
            w_tag_row[w_pick]   = r_ent_tag;
        end
    end

    // line store: clearing pass, registered read, write-back
    always_ff @(posedge i_clk) begin
        if (r_clr_busy) begin
            r_mem_valid[r_clr_idx] <= '0;
        end else if (w_done && w_active) begin
            r_mem_valid[r_ent_set] <= w_valid_row;
            r_mem_tag[r_ent_set]   <= w_tag_row;
            r_mem_stamp[r_ent_set] <= w_stamp_row;
        end
        if (o_pop) begin
            r_rd_valid <= r_mem_valid[i_entry[ADDR_WIDTH +: SIW]];
            r_rd_tag   <= r_mem_tag[i_entry[ADDR_WIDTH +: SIW]];
            r_rd_stamp <= r_mem_stamp[i_entry[ADDR_WIDTH +: SIW]];
        end
    end

    // clearing pass after reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_busy <= 1'b1;
            r_clr_idx  <= '0;
        end else if (r_clr_busy) begin
            if (r_clr_idx == SIW'(SETS - 1)) begin
                r_clr_busy <= 1'b0;
            end
            r_clr_idx <= r_clr_idx + 1'b1;
        end
    end

    // stamp and saturating totals
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stamp       <= '0;
            r_hit_total   <= '0;
            r_miss_total  <= '0;
            r_evict_total <= '0;
        end else if (w_done) begin
            r_stamp <= r_stamp + 1'b1;
            if (r_hit_total > TOTAL_MAX - 32'(w_hits)) begin
                r_hit_total <= TOTAL_MAX;
            end else begin
                r_hit_total <= r_hit_total + 32'(w_hits);
            end
            if (w_missed && (r_miss_total != TOTAL_MAX)) begin
                r_miss_total <= r_miss_total + 1'b1;
            end
            if (w_evicted && (r_evict_total != TOTAL_MAX)) begin
                r_evict_total <= r_evict_total + 1'b1;
            end
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_done) begin
            r_out_valid <= 1'b1;
        end else if (o_rsp.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_done) begin
            r_out_hits    <= w_hits;
            r_out_missed  <= w_missed;
            r_out_evicted <= w_evicted;
        end
    end

    // totals hold while a result waits, since no lookup completes then
    assign o_rsp.valid           = r_out_valid;
    assign o_rsp.hits_now        = r_out_hits;
    assign o_rsp.missed          = r_out_missed;
    assign o_rsp.evicted         = r_out_evicted;
    assign o_rsp.total_hits      = r_hit_total;
    assign o_rsp.total_misses    = r_miss_total;
    assign o_rsp.total_evictions = r_evict_total;

    // checks
    `SAC_ASSERT_NOW(a_no_pop_in_clear, i_clk, i_rst_n, r_clr_busy, !o_pop, "pop during clear")
    `SAC_ASSERT_NEXT(a_done_gives_result, i_clk, i_rst_n, w_done, o_rsp.valid, "result lost")
    `SAC_ASSERT_NOW(a_evict_is_miss, i_clk, i_rst_n, o_rsp.valid && o_rsp.evicted, o_rsp.missed, "evict without miss")
    `SAC_ASSERT_NEXT(a_stamp_step, i_clk, i_rst_n, w_done, r_stamp == STAMP_WIDTH'($past(r_stamp) + 1'b1), "stamp not advanced")

endmodule

[hw/rtl/set_assoc_cache_lru_sim_top.sv]
// ----------------------------------------------------------------------------
// set_assoc_cache_lru_sim_top
// Tag store of a set-associative cache with LRU replacement and hit, miss and
// eviction counters.
// ----------------------------------------------------------------------------
// Usage:
//   i_req carries one trace access per request (kind, byte address); o_rsp
//   returns one result per request: hits of this access, miss and eviction
//   flags and the saturating running totals after it.
//   The APB port sets set_bits (0x0), offset_bits (0x4) and ways_in_use (0x8);
//   write it only while no request is in flight.
//   A request passes the queue, a registered set read and the output register.
//   Lookups run one at a time, limited by the line store's single port: a
//   lookup reads the whole set, then resolves and writes it back.
//   A two-entry queue lets requests be accepted while the lookup side waits.
//   Reset: registers return to set_bits 4, offset_bits 4, ways_in_use 1, totals
//   and the stamp clear, and a clearing pass over all 2^MAX_SET_BITS sets (64 at
//   the default) invalidates them; i_req.ready stays low meanwhile.
//   Receiver stall: the result is held in an output register; the queue keeps
//   accepting until full, then i_req.ready drops.
// ----------------------------------------------------------------------------
module set_assoc_cache_lru_sim_top import sac_pkg::*; #(
    parameter int MAX_SET_BITS = DEF_MAX_SET_BITS,
    parameter int WAYS         = DEF_WAYS,
    parameter int ADDR_WIDTH   = DEF_ADDR_WIDTH,
    parameter int STAMP_WIDTH  = DEF_STAMP_WIDTH
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    sac_req_if.sink     i_req,
    sac_rsp_if.source   o_rsp,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    localparam int SIW = (MAX_SET_BITS > 0) ? MAX_SET_BITS : 1;
    localparam int EW  = 2 + SIW + ADDR_WIDTH;

    t_cfg          r_cfg;
    logic          w_wr;
    logic          w_clearing;
    logic          w_pop;
    logic          w_empty;
    logic [EW-1:0] w_entry;

    // APB register file
    assign pready = 1'b1;
    assign w_wr   = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.set_bits    <= RST_SET_BITS;
            r_cfg.offset_bits <= RST_OFFSET_BITS;
            r_cfg.ways_in_use <= RST_WAYS;
        end else if (w_wr) begin
            case (paddr[3:2])
                REG_SET_BITS:    r_cfg.set_bits    <= pwdata[2:0];
                REG_OFFSET_BITS: r_cfg.offset_bits <= pwdata[4:0];
                REG_WAYS:        r_cfg.ways_in_use <= pwdata[3:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[3:2])
            REG_SET_BITS:    prdata = {29'b0, r_cfg.set_bits};
            REG_OFFSET_BITS: prdata = {27'b0, r_cfg.offset_bits};
            REG_WAYS:        prdata = {28'b0, r_cfg.ways_in_use};
            default:         prdata = '0;
        endcase
    end

    // front: accept and decode
    sac_front #(
        .MAX_SET_BITS (MAX_SET_BITS),
        .ADDR_WIDTH   (ADDR_WIDTH),
        .SIW          (SIW),
        .EW           (EW)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (r_cfg),
        .i_clearing (w_clearing),
        .i_req      (i_req),
        .i_pop      (w_pop),
        .o_entry    (w_entry),
        .o_empty    (w_empty)
    );

    // back: lookup, replacement and counters
    sac_back #(
        .MAX_SET_BITS (MAX_SET_BITS),
        .WAYS         (WAYS),
        .ADDR_WIDTH   (ADDR_WIDTH),
        .STAMP_WIDTH  (STAMP_WIDTH),
        .SIW          (SIW),
        .EW           (EW)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (r_cfg),
        .o_clearing (w_clearing),
        .i_entry    (w_entry),
        .i_empty    (w_empty),
        .o_pop      (w_pop),
        .o_rsp      (o_rsp)
    );

endmodule

[sim/set_assoc_cache_lru_sim_top_test.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// set_assoc_cache_lru_sim_top_test
// Drives trace accesses into the cache tag store and checks every lookup
// result against a behavioral LRU tag store kept in the bench, or against the
// typed rows of a directed table that covers reset, split extremes and kinds;
// random phases follow, each with its own set/offset split and way count.
// ----------------------------------------------------------------------------
module set_assoc_cache_lru_sim_top_test;
    import sac_pkg::*;

    localparam int MAX_SET_BITS  = DEF_MAX_SET_BITS;
    localparam int WAYS          = DEF_WAYS;
    localparam int LINES         = (1 << MAX_SET_BITS) * WAYS;
    localparam int SETTLE_CYCLES = 4;
    localparam int CYCLE_LIMIT   = 400000;
    localparam int PHASES        = 12;
    localparam int PHASE_ITEMS   = 52;
    localparam int HOT_TAGS      = 16;
    localparam int TABLE_ROWS    = 34;

    // one lookup result as it leaves the block
    typedef struct packed {
        logic [1:0]  hits_now;
        logic        missed;
        logic        evicted;
        logic [31:0] total_hits;
        logic [31:0] total_misses;
        logic [31:0] total_evictions;
    } t_lookup;

    typedef enum logic {ROW_ACCESS, ROW_CONFIG} t_row_op;

    // directed table row: a register write or one access
    typedef struct packed {
        t_row_op     op;
        logic [1:0]  reg_idx;
        logic [31:0] wdata;
        logic [1:0]  kind;
        logic [31:0] addr;
        logic        typed;
        t_lookup     want;
    } t_stim_row;

    logic        i_clk;
    logic        i_rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [3:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    sac_req_if #(.ADDR_WIDTH(32)) req_ch ();
    sac_rsp_if rsp_ch ();

    set_assoc_cache_lru_sim_top DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch),
        .o_rsp   (rsp_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // bench copy of the tag store and its configuration
    logic [2:0]  cfg_set_bits;
    logic [4:0]  cfg_offset_bits;
    logic [3:0]  cfg_ways;
    bit          line_valid [LINES];
    logic [31:0] line_tag   [LINES];
    logic [31:0] line_stamp [LINES];
    logic [31:0] stamp_now;
    logic [31:0] hit_count;
    logic [31:0] miss_count;
    logic [31:0] evict_count;

    t_lookup pending_lookups [$];
    int      mismatches;
    int      cycles;
    bit      calm;

    // directed requests: reset geometry first, then split and way extremes
    t_stim_row directed_table [TABLE_ROWS] = '{
        '{ROW_ACCESS, REG_SET_BITS, 32'd0, KIND_LOAD, 32'h0000_0000, 1'b1,
          '{2'd0, 1'b1, 1'b0, 32'd0, 32'd1, 32'd0}},
        '{ROW_ACCESS, REG_SET_BITS, 32'd0, KIND_LOAD, 32'h0000_0004, 1'b1,
          '{2'd1, 1'b0, 1'b0, 32'd1, 32'd1, 32'd0}},
        '{ROW_ACCESS, REG_SET_BITS, 32'd0, KIND_MODIFY, 32'h0000_000F, 1'b1,
          '{2'd2, 1'b0, 1'b0, 32'd3, 32'd1, 32'd0}},
        '{ROW_ACCESS, REG_SET_BITS, 32'd0, KIND_STORE, 32'hFFFF_FFFF, 1'b1,
          '{2'd0, 1'b1, 1'b0, 32'd3, 32'd2, 32'd0}},
        '{ROW_ACCESS, REG_SET_BITS, 32'd0, KIND_NONE, 32'hFFFF_FFFF, 1'b1,
          '{2'd0, 1'b0, 1'b0, 32'd3, 32'd2, 32'd0}},
        '{ROW_ACCESS, REG_SET_BITS, 32'd0, KIND_LOAD, 32'h0000_0100, 1'b1,
          '{2'd0, 1'b1, 1'b1, 32'd3, 32'd3, 32'd1}},
        '{ROW_ACCESS, REG_SET_BITS, 32'd0, KIND_MODIFY, 32'h0000_0000, 1'b1,
          '{2'd1, 1'b1, 1'b1, 32'd4, 32'd4, 32'd2}},
        '{ROW_ACCESS, REG_SET_BITS, 32'd0, KIND_STORE, 32'h0000_0100, 1'b1,
          '{2'd0, 1'b1, 1'b1, 32'd4, 32'd5, 32'd3}},
        '{ROW_ACCESS, REG_SET_BITS, 32'd0, KIND_NONE, 32'h0000_0000, 1'b1,
          '{2'd0, 1'b0, 1'b0, 32'd4, 32'd5, 32'd3}},
        // four ways: fill, then evict the oldest
        '{ROW_CONFIG, REG_WAYS, 32'd4, KIND_LOAD, 32'd0, 1'b0, '0},
        '{ROW_ACCESS, REG_SET_BITS, 32'd0, KIND_LOAD, 32'h0000_0000, 1'b0, '0},
        '{ROW_ACCESS, REG_SET_BITS, 32'd0, KIND_LOAD, 32'h0000_0200, 1'b0, '0},
        '{ROW_ACCESS, REG_SET_BITS, 32'd0, KIND_STORE, 32'h0000_0300, 1'b0, '0},
        '{ROW_ACCESS, REG_SET_BITS, 32'd0, KIND_LOAD, 32'h0000_0400, 1'b0, '0},
        '{ROW_ACCESS, REG_SET_BITS, 32'd0, KIND_MODIFY, 32'h0000_0100, 1'b0, '0},
        // zero ways acts as one
        '{ROW_CONFIG, REG_WAYS, 32'd0, KIND_LOAD, 32'd0, 1'b0, '0},
        '{ROW_ACCESS, REG_SET_BITS, 32'd0, KIND_LOAD, 32'h0000_0300, 1'b0, '0},
        // set bits above max clamp; wide split leaves no tag
        '{ROW_CONFIG, REG_SET_BITS, 32'd7, KIND_LOAD, 32'd0, 1'b0, '0},
        '{ROW_CONFIG, REG_OFFSET_BITS, 32'd31, KIND_LOAD, 32'd0, 1'b0, '0},
        '{ROW_ACCESS, REG_SET_BITS, 32'd0, KIND_LOAD, 32'h8000_0000, 1'b0, '0},
        '{ROW_ACCESS, REG_SET_BITS, 32'd0, KIND_MODIFY, 32'h7FFF_FFFF, 1'b0, '0},
        '{ROW_ACCESS, REG_SET_BITS, 32'd0, KIND_STORE, 32'hFFFF_FFFF, 1'b0, '0},
        // ways above max clamp; one set, full address as tag
        '{ROW_CONFIG, REG_WAYS, 32'd15, KIND_LOAD, 32'd0, 1'b0, '0},
        '{ROW_CONFIG, REG_SET_BITS, 32'd0, KIND_LOAD, 32'd0, 1'b0, '0},
        '{ROW_CONFIG, REG_OFFSET_BITS, 32'd0, KIND_LOAD, 32'd0, 1'b0, '0},
        '{ROW_ACCESS, REG_SET_BITS, 32'd0, KIND_MODIFY, 32'hFFFF_FFFF, 1'b0, '0},
        '{ROW_ACCESS, REG_SET_BITS, 32'd0, KIND_LOAD, 32'hFFFF_FFFE, 1'b0, '0},
        '{ROW_ACCESS, REG_SET_BITS, 32'd0, KIND_STORE, 32'hFFFF_FFFF, 1'b0, '0},
        '{ROW_ACCESS, REG_SET_BITS, 32'd0, KIND_NONE, 32'h5555_5555, 1'b0, '0},
        '{ROW_ACCESS, REG_SET_BITS, 32'd0, KIND_LOAD, 32'hAAAA_AAAA, 1'b0, '0},
        // widest set split with a large block
        '{ROW_CONFIG, REG_SET_BITS, 32'd6, KIND_LOAD, 32'd0, 1'b0, '0},
        '{ROW_CONFIG, REG_OFFSET_BITS, 32'd16, KIND_LOAD, 32'd0, 1'b0, '0},
        '{ROW_ACCESS, REG_SET_BITS, 32'd0, KIND_LOAD, 32'h1234_5678, 1'b0, '0},
        '{ROW_ACCESS, REG_SET_BITS, 32'd0, KIND_STORE, 32'h1234_0000, 1'b0, '0}
    };

    // clock
    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    function automatic logic [31:0] sat_sum(logic [31:0] acc, logic [1:0] inc);
        return ({1'b0, acc} + inc > {1'b0, TOTAL_MAX}) ? TOTAL_MAX : acc + inc;
    endfunction

    // LRU lookup of one access; updates the bench tag store and totals
    function automatic t_lookup lru_lookup(logic [1:0] kind, logic [31:0] addr);
        t_lookup     res;
        int          sb;
        int          bb;
        int          ways;
        int          base;
        int          pick;
        logic [63:0] wide_addr;
        logic [31:0] tag_val;
        bit          found;
        bit          empty;
        res = '0;
        sb = (cfg_set_bits > MAX_SET_BITS) ? MAX_SET_BITS : int'(cfg_set_bits);
        bb = int'(cfg_offset_bits);
        ways = (cfg_ways == 0) ? 1 : ((cfg_ways > WAYS) ? WAYS : int'(cfg_ways));
        if (kind != KIND_NONE) begin
            wide_addr = {32'd0, addr};
            base = int'((wide_addr >> bb) & ((64'd1 << sb) - 64'd1)) * WAYS;
            tag_val = 32'(wide_addr >> (sb + bb));
            found = 1'b0;
            pick = 0;
            for (int w = 0; w < ways; w++) begin
                if (!found && line_valid[base + w] && line_tag[base + w] == tag_val) begin
                    found = 1'b1;
                    pick = w;
                end
            end
            if (found) begin
                res.hits_now = 2'd1;
                line_stamp[base + pick] = stamp_now;
            end else begin
                res.missed = 1'b1;
                empty = 1'b0;
                for (int w = 0; w < ways; w++) begin
                    if (!empty && !line_valid[base + w]) begin
                        empty = 1'b1;
                        pick = w;
                    end
                end
                // all used ways valid: oldest stamp goes, ties to lowest way
                if (!empty) begin
                    res.evicted = 1'b1;
                    pick = 0;
                    for (int w = 1; w < ways; w++) begin
                        if (line_stamp[base + w] < line_stamp[base + pick]) pick = w;
                    end
                end
                line_valid[base + pick] = 1'b1;
                line_tag[base + pick] = tag_val;
                line_stamp[base + pick] = stamp_now;
            end
            // second access of a modify always hits
            if (kind == KIND_MODIFY) res.hits_now = res.hits_now + 2'd1;
        end
        hit_count = sat_sum(hit_count, res.hits_now);
        miss_count = sat_sum(miss_count, {1'b0, res.missed});
        evict_count = sat_sum(evict_count, {1'b0, res.evicted});
        stamp_now = stamp_now + 32'd1;
        res.total_hits = hit_count;
        res.total_misses = miss_count;
        res.total_evictions = evict_count;
        return res;
    endfunction

    // mostly short idle stretches, a few long ones
    function automatic int idle_length();
        int pick;
        pick = $urandom_range(0, 19);
        if (pick < 16) return $urandom_range(1, 2);
        if (pick < 19) return $urandom_range(3, 8);
        return $urandom_range(20, 40);
    endfunction

    // send one request and queue its expected lookup
    task automatic send_access(logic [1:0] kind, logic [31:0] addr, bit typed,
                               t_lookup typed_want);
        t_lookup predicted;
        req_ch.valid <= 1'b1;
        req_ch.kind <= kind;
        req_ch.address <= addr;
        do @(posedge i_clk); while (!req_ch.ready);
        predicted = lru_lookup(kind, addr);
        pending_lookups.push_back(typed ? typed_want : predicted);
    endtask

    task automatic sender_gap();
        int gap;
        gap = (!calm && $urandom_range(0, 2) == 0) ? idle_length() : 0;
        if (gap > 0) begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // hold off until every expected lookup has come back
    task automatic wait_drained();
        req_ch.valid <= 1'b0;
        while (pending_lookups.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // APB write, only with the block idle
    task automatic write_register(logic [1:0] idx, logic [31:0] value);
        wait_drained();
        @(posedge i_clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (idx)
            REG_SET_BITS:    cfg_set_bits = value[2:0];
            REG_OFFSET_BITS: cfg_offset_bits = value[4:0];
            REG_WAYS:        cfg_ways = value[3:0];
            default: ;
        endcase
    endtask

    // result side back-pressure
    initial begin
        int stall_left;
        stall_left = 0;
        rsp_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (stall_left > 0) begin
                rsp_ch.ready <= 1'b0;
                stall_left--;
            end else begin
                rsp_ch.ready <= 1'b1;
                if (!calm && $urandom_range(0, 3) == 0) stall_left = idle_length();
            end
        end
    end

    task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
            mismatches++;
        end
    endtask

    // compare each returned lookup with the oldest expectation
    always @(posedge i_clk) begin
        t_lookup want;
        if (i_rst_n && rsp_ch.valid && rsp_ch.ready) begin
            if (pending_lookups.size() == 0) begin
                $display("%0t: result with none expected, expected nothing, actual %0h",
                         $time, rsp_ch.total_hits);
                mismatches++;
            end else begin
                want = pending_lookups.pop_front();
                check_field("hits_now", 32'(want.hits_now), 32'(rsp_ch.hits_now));
                check_field("missed", 32'(want.missed), 32'(rsp_ch.missed));
                check_field("evicted", 32'(want.evicted), 32'(rsp_ch.evicted));
                check_field("total_hits", want.total_hits, rsp_ch.total_hits);
                check_field("total_misses", want.total_misses, rsp_ch.total_misses);
                check_field("total_evictions", want.total_evictions,
                            rsp_ch.total_evictions);
            end
        end
    end

    // run time limit
    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    // stimulus
    initial begin
        logic [2:0]  sb_w;
        logic [4:0]  bb_w;
        logic [3:0]  ways_w;
        int          sb_eff;
        int          pick;
        logic [1:0]  kind;
        logic [31:0] addr;
        logic [63:0] wide;
        logic [31:0] hot_sets [2];
        logic [31:0] hot_tags [HOT_TAGS];

        mismatches = 0;
        cycles = 0;
        calm = 1'b0;
        i_rst_n <= 1'b0;
        req_ch.valid <= 1'b0;
        req_ch.kind <= KIND_LOAD;
        req_ch.address <= '0;
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= '0;
        pwdata <= '0;

        cfg_set_bits = RST_SET_BITS;
        cfg_offset_bits = RST_OFFSET_BITS;
        cfg_ways = RST_WAYS;
        stamp_now = '0;
        hit_count = '0;
        miss_count = '0;
        evict_count = '0;
        for (int i = 0; i < LINES; i++) line_valid[i] = 1'b0;

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed table
        foreach (directed_table[r]) begin
            if (directed_table[r].op == ROW_CONFIG) begin
                write_register(directed_table[r].reg_idx, directed_table[r].wdata);
            end else begin
                sender_gap();
                send_access(directed_table[r].kind, directed_table[r].addr,
                            directed_table[r].typed, directed_table[r].want);
            end
        end

        // random phases, each with its own geometry
        for (int phase = 0; phase < PHASES; phase++) begin
            case (phase)
                0: begin sb_w = 3'd0; bb_w = 5'd0;  ways_w = 4'd1;  end
                1: begin sb_w = 3'd6; bb_w = 5'd16; ways_w = 4'd8;  end
                2: begin sb_w = 3'd7; bb_w = 5'd31; ways_w = 4'd15; end
                3: begin sb_w = 3'd3; bb_w = 5'd2;  ways_w = 4'd0;  end
                default: begin
                    sb_w = 3'($urandom_range(0, 7));
                    bb_w = ($urandom_range(0, 3) == 0) ? 5'($urandom_range(17, 31))
                                                        : 5'($urandom_range(0, 16));
                    ways_w = 4'($urandom_range(0, 15));
                end
            endcase
            // upper data bits are don't-care
            write_register(REG_SET_BITS, ($urandom & ~32'h7) | sb_w);
            write_register(REG_OFFSET_BITS, ($urandom & ~32'h1F) | bb_w);
            write_register(REG_WAYS, ($urandom & ~32'hF) | ways_w);
            calm = (phase % 4 == 1);

            // a few hot sets and tags so that lines get reused and evicted
            sb_eff = (cfg_set_bits > MAX_SET_BITS) ? MAX_SET_BITS : int'(cfg_set_bits);
            foreach (hot_sets[i]) hot_sets[i] = $urandom;
            foreach (hot_tags[i]) hot_tags[i] = $urandom;

            for (int n = 0; n < PHASE_ITEMS; n++) begin
                pick = $urandom_range(0, 19);
                if (pick == 0) kind = KIND_NONE;
                else if (pick < 9) kind = KIND_LOAD;
                else if (pick < 15) kind = KIND_STORE;
                else kind = KIND_MODIFY;

                if ($urandom_range(0, 3) == 0) begin
                    addr = $urandom;
                end else begin
                    wide = ({32'd0, hot_tags[$urandom_range(0, HOT_TAGS - 1)]}
                               << (sb_eff + cfg_offset_bits))
                         | (({32'd0, hot_sets[$urandom_range(0, 1)]}
                               & ((64'd1 << sb_eff) - 64'd1)) << cfg_offset_bits)
                         | ({32'd0, $urandom} & ((64'd1 << cfg_offset_bits) - 64'd1));
                    addr = wide[31:0];
                end

                // sender waits for a full drain now and then
                if ((phase == 2 && n == 20) || $urandom_range(0, 63) == 0)
                    wait_drained();
                sender_gap();
                send_access(kind, addr, 1'b0, '0);
            end
        end

        wait_drained();
        repeat (8) @(posedge i_clk);
        if (mismatches == 0 && pending_lookups.size() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
